/* src/hdlcd_pkg.sv */
package hdlcd_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_XOR   = 3'd4;

  localparam logic [15:0] MIN_FRAME_RESET = 16'd4;
  localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;
  localparam logic [7:0]  DELIM_RESET     = 8'h7E;
  localparam logic [7:0]  ESCAPE_RESET    = 8'h7D;
  localparam logic [7:0]  ESC_XOR_RESET   = 8'h20;

  localparam logic [15:0] RAW_COUNT_MAX = 16'hFFFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_NO_START   = 3'd2;
  localparam logic [2:0] ST_NO_END     = 3'd3;
  localparam logic [2:0] ST_BAD_CRC    = 3'd4;

  localparam int unsigned CMD_DEPTH_DEFAULT = 2;
  localparam int unsigned OUT_DEPTH_DEFAULT = 2;

  // one classified raw byte, handed from front to back
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       start;
    logic       last;
    logic [2:0] pre_status;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic [2:0] status;
  } resp_t;

  typedef enum logic {
    B_RUN,
    B_STATUS
  } back_state_t;

  // CRC-16/CCITT, poly 0x1021, one byte per call
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    begin
      c = {crc_in[7:0], crc_in[15:8]};
      c = c ^ {8'h00, b};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      crc_step = c;
    end
  endfunction

endpackage

/* src/hdlcd_fifo.sv */
module hdlcd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/hdlcd_front.sv */
module hdlcd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [7:0]                          rx_byte,
  input  logic                                is_last,
  input  logic                                cfg_we,
  input  logic [hdlcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdlcd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output hdlcd_pkg::cmd_t                     cmd
);

  logic [15:0] min_frame;
  logic [15:0] max_frame;
  logic [7:0]  delim;
  logic [7:0]  escape;
  logic [7:0]  esc_xor;

  logic [15:0] raw_count;
  logic        start_seen;
  logic        esc_pending;

  logic        first;
  logic [15:0] raw_count_next;
  logic        start_next;
  logic        esc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame <= hdlcd_pkg::MIN_FRAME_RESET;
      max_frame <= hdlcd_pkg::MAX_FRAME_RESET;
      delim     <= hdlcd_pkg::DELIM_RESET;
      escape    <= hdlcd_pkg::ESCAPE_RESET;
      esc_xor   <= hdlcd_pkg::ESC_XOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hdlcd_pkg::CFG_MIN_FRAME: min_frame <= cfg_data;
        hdlcd_pkg::CFG_MAX_FRAME: max_frame <= cfg_data;
        hdlcd_pkg::CFG_DELIM:     delim     <= cfg_data[7:0];
        hdlcd_pkg::CFG_ESCAPE:    escape    <= cfg_data[7:0];
        hdlcd_pkg::CFG_ESC_XOR:   esc_xor   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    first          = (raw_count == '0);
    raw_count_next = (raw_count != hdlcd_pkg::RAW_COUNT_MAX) ? raw_count + 16'd1 : raw_count;
    start_next     = first ? (rx_byte == delim) : start_seen;
    esc_next       = esc_pending;

    cmd.has_byte   = 1'b0;
    cmd.data       = rx_byte;
    cmd.start      = start_next;
    cmd.last       = is_last;
    cmd.pre_status = hdlcd_pkg::ST_OK;

    if (esc_pending) begin
      // first byte never sees a pending escape; it is cleared at frame end
      cmd.has_byte = 1'b1;
      cmd.data     = rx_byte ^ esc_xor;
      esc_next     = 1'b0;
    end else if (!is_last && !first) begin
      if (rx_byte == escape) begin
        esc_next = 1'b1;
      end else begin
        cmd.has_byte = 1'b1;
      end
    end

    if (raw_count_next < min_frame || raw_count_next > max_frame) begin
      cmd.pre_status = hdlcd_pkg::ST_BAD_LENGTH;
    end else if (!start_next) begin
      cmd.pre_status = hdlcd_pkg::ST_NO_START;
    end else if (rx_byte != delim) begin
      cmd.pre_status = hdlcd_pkg::ST_NO_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count   <= '0;
      start_seen  <= 1'b0;
      esc_pending <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        raw_count   <= '0;
        start_seen  <= 1'b0;
        esc_pending <= 1'b0;
      end else begin
        raw_count   <= raw_count_next;
        start_seen  <= start_next;
        esc_pending <= esc_next;
      end
    end
  end

endmodule

/* src/hdlcd_back.sv */
module hdlcd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  hdlcd_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  input  logic              out_full,
  output logic              out_push,
  output hdlcd_pkg::resp_t  resp
);

  hdlcd_pkg::back_state_t state;
  hdlcd_pkg::back_state_t state_next;

  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [1:0]  held_count;
  logic [15:0] crc;

  logic        fire;
  logic        eff_has;
  logic        shift;
  logic        emit;
  logic [7:0]  held0_next;
  logic [7:0]  held1_next;
  logic [1:0]  held_count_next;
  logic [15:0] crc_next;
  logic [2:0]  frame_status;

  assign fire = cmd_valid && !out_full;

  // decoded-byte hold-back and CRC, as seen after this command's byte
  always_comb begin
    eff_has         = cmd.has_byte && (state == hdlcd_pkg::B_RUN);
    shift           = eff_has && (held_count == 2'd2);
    emit            = shift && cmd.start;
    held0_next      = held0;
    held1_next      = held1;
    held_count_next = held_count;
    crc_next        = crc;
    if (shift) begin
      crc_next   = hdlcd_pkg::crc_step(crc, held0);
      held0_next = held1;
      held1_next = cmd.data;
    end else if (eff_has) begin
      if (held_count == 2'd0) begin
        held0_next = cmd.data;
      end else begin
        held1_next = cmd.data;
      end
      held_count_next = held_count + 2'd1;
    end

    if (cmd.pre_status != hdlcd_pkg::ST_OK) begin
      frame_status = cmd.pre_status;
    end else if (held_count_next != 2'd2) begin
      frame_status = hdlcd_pkg::ST_BAD_CRC;
    end else if ({held1_next, held0_next} != crc_next) begin
      frame_status = hdlcd_pkg::ST_BAD_CRC;
    end else begin
      frame_status = hdlcd_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hdlcd_pkg::B_RUN: begin
        if (fire && emit && cmd.last) begin
          state_next = hdlcd_pkg::B_STATUS;
        end
      end
      hdlcd_pkg::B_STATUS: begin
        if (fire) begin
          state_next = hdlcd_pkg::B_RUN;
        end
      end
      default: state_next = hdlcd_pkg::B_RUN;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    out_push       = 1'b0;
    resp.out_byte  = 8'h00;
    resp.frame_end = 1'b0;
    resp.status    = hdlcd_pkg::ST_OK;
    case (state)
      hdlcd_pkg::B_RUN: begin
        if (fire) begin
          if (emit) begin
            out_push      = 1'b1;
            resp.out_byte = held0;
            cmd_pop       = !cmd.last;
          end else begin
            cmd_pop = 1'b1;
            if (cmd.last) begin
              out_push       = 1'b1;
              resp.frame_end = 1'b1;
              resp.status    = frame_status;
            end
          end
        end
      end
      hdlcd_pkg::B_STATUS: begin
        if (fire) begin
          cmd_pop        = 1'b1;
          out_push       = 1'b1;
          resp.frame_end = 1'b1;
          resp.status    = frame_status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hdlcd_pkg::B_RUN;
      held0      <= 8'h00;
      held1      <= 8'h00;
      held_count <= 2'd0;
      crc        <= hdlcd_pkg::CRC_INIT;
    end else begin
      state <= state_next;
      if (cmd_pop && cmd.last) begin
        held0      <= 8'h00;
        held1      <= 8'h00;
        held_count <= 2'd0;
        crc        <= hdlcd_pkg::CRC_INIT;
      end else if (fire) begin
        held0      <= held0_next;
        held1      <= held1_next;
        held_count <= held_count_next;
        crc        <= crc_next;
      end
    end
  end

endmodule

/* src/hdlc_frame_decoder_unit.sv */
// HDLC deframer with CRC-16 check.
// Input queue: raise push with rx_byte and is_last; a byte is taken on a clock
// edge where push is high and full is low. is_last marks the closing delimiter.
// Output queue: while empty is low the oldest result sits on out_byte,
// frame_end and status; pop takes it. Payload results carry frame_end low,
// and the closing result carries frame_end high with the frame status.
// Config: cfg_valid/cfg_ready write cfg_data into register cfg_index
// (0 min length, 1 max length, 2 delimiter, 3 escape, 4 escape mask);
// cfg_ready is always high. Write only while no frame is in flight.
// Throughput: one raw byte per cycle while full is low; when a frame's last byte
// follows an escape and yields a payload byte, the back end first writes the
// payload result and then, from state B_STATUS, the status result, since the
// back end writes one result per cycle into the output queue.
// Reset clears both queues, the frame state and restores register defaults.
// If pop stays low the output queue fills, the back end holds, the command
// queue fills and full rises; nothing is dropped.
module hdlc_frame_decoder_unit #(
  parameter int unsigned CMD_DEPTH = hdlcd_pkg::CMD_DEPTH_DEFAULT,
  parameter int unsigned OUT_DEPTH = hdlcd_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        rx_byte,
  input  logic                              is_last,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        out_byte,
  output logic                              frame_end,
  output logic [2:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdlcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hdlcd_pkg::cmd_t  front_cmd;
  hdlcd_pkg::cmd_t  back_cmd;
  hdlcd_pkg::resp_t back_resp;
  hdlcd_pkg::resp_t head_resp;

  logic accept;
  logic cmd_empty;
  logic cmd_pop;
  logic out_full;
  logic out_push;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  hdlcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .is_last   (is_last),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (front_cmd)
  );

  hdlcd_fifo #(
    .WIDTH ($bits(hdlcd_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_cmd),
    .rd_en   (cmd_pop),
    .rd_data (back_cmd),
    .full    (full),
    .empty   (cmd_empty)
  );

  hdlcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .resp      (back_resp)
  );

  hdlcd_fifo #(
    .WIDTH ($bits(hdlcd_pkg::resp_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (back_resp),
    .rd_en   (pop),
    .rd_data (head_resp),
    .full    (out_full),
    .empty   (empty)
  );

  assign out_byte  = head_resp.out_byte;
  assign frame_end = head_resp.frame_end;
  assign status    = head_resp.status;

  a_payload_status_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_end) |-> (status == hdlcd_pkg::ST_OK))
    else $error("payload result with nonzero status");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> (out_byte == 8'h00))
    else $error("status result with nonzero byte");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status <= hdlcd_pkg::ST_BAD_CRC))
    else $error("status code out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

/* bench/tb_hdlc_frame_decoder_unit.sv */
`timescale 1ns / 100ps

module tb_hdlc_frame_decoder_unit;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [hdlcd_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  typedef enum int {
    FL_NONE,
    FL_BAD_CRC,
    FL_NO_START,
    FL_NO_END,
    FL_ESC_LAST
  } flaw_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             full;
  logic [7:0]                       rx_byte = 8'h00;
  logic                             is_last = 1'b0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic [7:0]                       out_byte;
  logic                             frame_end;
  logic [2:0]                       status;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [hdlcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hdlcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // deframer state as the block should hold it
  logic [15:0] min_len;
  logic [15:0] max_len;
  logic [7:0]  delim;
  logic [7:0]  esc_code;
  logic [7:0]  esc_mask;
  logic [7:0]  held [2];
  logic [1:0]  held_n;
  logic        esc_open;
  logic [15:0] crc_acc;
  logic [15:0] raw_n;
  logic        start_ok;

  rx_item_t           send_q[$];
  hdlcd_pkg::resp_t   want_q[$];
  logic [7:0]         body_q[$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int take_gap = 0;
  bit tail_quiet = 1'b0;

  hdlc_frame_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .is_last   (is_last),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bitwise CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

  task automatic clear_frame_state();
    held[0] = 8'h00;
    held[1] = 8'h00;
    held_n = 2'd0;
    esc_open = 1'b0;
    crc_acc = hdlcd_pkg::CRC_INIT;
    raw_n = 16'd0;
    start_ok = 1'b0;
  endtask

  task automatic apply_register(input logic [hdlcd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [hdlcd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      hdlcd_pkg::CFG_MIN_FRAME: min_len = val;
      hdlcd_pkg::CFG_MAX_FRAME: max_len = val;
      hdlcd_pkg::CFG_DELIM:     delim = val[7:0];
      hdlcd_pkg::CFG_ESCAPE:    esc_code = val[7:0];
      hdlcd_pkg::CFG_ESC_XOR:   esc_mask = val[7:0];
      default: ;
    endcase
  endtask

  // the two newest decoded bytes stay back as the received CRC
  task automatic take_decoded(input logic [7:0] d);
    hdlcd_pkg::resp_t r;
    if (held_n == 2'd2) begin
      crc_acc = crc_next(crc_acc, held[0]);
      if (start_ok) begin
        r.out_byte = held[0];
        r.frame_end = 1'b0;
        r.status = hdlcd_pkg::ST_OK;
        want_q.push_back(r);
      end
      held[0] = held[1];
      held[1] = d;
    end else begin
      held[held_n[0]] = d;
      held_n = held_n + 2'd1;
    end
  endtask

  task automatic predict_item(input logic [7:0] d, input logic fin);
    hdlcd_pkg::resp_t r;
    logic             lead;
    lead = (raw_n == 16'd0);
    if (raw_n != hdlcd_pkg::RAW_COUNT_MAX) raw_n = raw_n + 16'd1;
    if (lead) start_ok = (d == delim);
    if (!fin) begin
      if (!lead) begin
        if (esc_open) begin
          esc_open = 1'b0;
          take_decoded(d ^ esc_mask);
        end else if (d == esc_code) begin
          esc_open = 1'b1;
        end else begin
          take_decoded(d);
        end
      end
    end else begin
      if (esc_open) begin
        esc_open = 1'b0;
        take_decoded(d ^ esc_mask);
      end
      r.out_byte = 8'h00;
      r.frame_end = 1'b1;
      if (raw_n < min_len || raw_n > max_len) r.status = hdlcd_pkg::ST_BAD_LENGTH;
      else if (!start_ok) r.status = hdlcd_pkg::ST_NO_START;
      else if (d != delim) r.status = hdlcd_pkg::ST_NO_END;
      else if (held_n != 2'd2) r.status = hdlcd_pkg::ST_BAD_CRC;
      else if ({held[1], held[0]} != crc_acc) r.status = hdlcd_pkg::ST_BAD_CRC;
      else r.status = hdlcd_pkg::ST_OK;
      want_q.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result();
    hdlcd_pkg::resp_t w;
    if (want_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %02h end %0b status %0d",
                                out_byte, frame_end, status));
    end else begin
      w = want_q.pop_front();
      if (out_byte !== w.out_byte)
        report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, w.out_byte));
      if (frame_end !== w.frame_end)
        report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, w.frame_end));
      if (status !== w.status)
        report_mismatch($sformatf("status %0d, want %0d", status, w.status));
    end
  endtask

  // sender and receiver, both with random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (send_q.size() == 0) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        rx_byte <= send_q[0].data;
        is_last <= send_q[0].last;
        if (!tail_quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 5);
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!tail_quiet && $urandom_range(0, 9) == 0) take_gap = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      min_len = hdlcd_pkg::MIN_FRAME_RESET;
      max_len = hdlcd_pkg::MAX_FRAME_RESET;
      delim = hdlcd_pkg::DELIM_RESET;
      esc_code = hdlcd_pkg::ESCAPE_RESET;
      esc_mask = hdlcd_pkg::ESC_XOR_RESET;
      clear_frame_state();
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (push && !full) begin
        predict_item(rx_byte, is_last);
        void'(send_q.pop_front());
      end
      if (pop && !empty) check_result();
      if ((cfg_valid && cfg_ready) || (push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [hdlcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued byte is sent and every result is back, then let the block settle
  task automatic drain();
    while (send_q.size() != 0 || want_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // body_q holds the payload; append its CRC, stuff it and add delimiters
  task automatic queue_frame(input flaw_t flaw);
    logic [15:0] c;
    logic [7:0]  v;
    logic [7:0]  raw_q[$];
    int          k;
    c = hdlcd_pkg::CRC_INIT;
    foreach (body_q[i]) c = crc_next(c, body_q[i]);
    body_q.push_back(c[7:0]);
    body_q.push_back(c[15:8]);
    if (flaw == FL_BAD_CRC) begin
      k = $urandom_range(0, body_q.size() - 1);
      body_q[k] = body_q[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    raw_q.push_back(flaw == FL_NO_START ? delim ^ 8'($urandom_range(1, 255)) : delim);
    foreach (body_q[i]) begin
      v = body_q[i];
      if (v == esc_code || v == delim || $urandom_range(0, 15) == 0) begin
        raw_q.push_back(esc_code);
        raw_q.push_back(v ^ esc_mask);
      end else begin
        raw_q.push_back(v);
      end
    end
    if (flaw == FL_ESC_LAST) raw_q.push_back(esc_code);
    raw_q.push_back(flaw == FL_NO_END ? delim ^ 8'($urandom_range(1, 255)) : delim);
    foreach (raw_q[i]) send_q.push_back('{raw_q[i], i == raw_q.size() - 1});
    body_q.delete();
  endtask

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_q.push_back('{8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0)});
    end
  endtask

  task automatic queue_random(input int target, input int max_pay);
    int stop;
    int pick;
    int n;
    stop = send_q.size() + target;
    while (send_q.size() < stop) begin
      pick = $urandom_range(0, 19);
      if (pick >= 17) begin
        queue_noise($urandom_range(1, 8));
      end else begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_pay) : $urandom_range(0, 6);
        repeat (n) body_q.push_back(8'($urandom));
        queue_frame(pick <= 12 ? FL_NONE : flaw_t'(pick - 12));
      end
    end
  endtask

  initial begin
    logic [7:0] d;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: empty payload, stuffed bytes, each kind of broken frame
    queue_frame(FL_NONE);
    body_q = '{8'h00, 8'hFF, delim, esc_code};
    queue_frame(FL_NONE);
    body_q = '{8'h5A};
    queue_frame(FL_BAD_CRC);
    body_q = '{8'h11};
    queue_frame(FL_NO_START);
    body_q = '{8'h22};
    queue_frame(FL_NO_END);
    body_q = '{8'h33};
    queue_frame(FL_ESC_LAST);
    send_q.push_back('{delim, 1'b1});
    queue_random(300, 24);
    drain();

    // no minimum, tight maximum, extreme codes; upper data bits must be dropped
    write_reg(hdlcd_pkg::CFG_MIN_FRAME, 16'h0000);
    write_reg(hdlcd_pkg::CFG_MAX_FRAME, 16'd12);
    write_reg(hdlcd_pkg::CFG_DELIM, 16'hA500);
    write_reg(hdlcd_pkg::CFG_ESCAPE, 16'h5AFF);
    write_reg(hdlcd_pkg::CFG_ESC_XOR, 16'h3CFF);
    write_reg(CFG_NO_REG, 16'($urandom));
    end_writes();
    send_q.push_back('{delim, 1'b1});
    send_q.push_back('{delim, 1'b0});
    send_q.push_back('{delim, 1'b1});
    queue_random(200, 10);
    drain();

    // minimum above maximum: every frame fails on length
    write_reg(hdlcd_pkg::CFG_MIN_FRAME, 16'hFFFF);
    write_reg(hdlcd_pkg::CFG_MAX_FRAME, 16'h0000);
    write_reg(hdlcd_pkg::CFG_DELIM, 16'h00FF);
    write_reg(hdlcd_pkg::CFG_ESCAPE, 16'hFF00);
    write_reg(hdlcd_pkg::CFG_ESC_XOR, 16'h0000);
    end_writes();
    queue_random(120, 12);
    drain();

    // length window from 2 to 0xFFFF with random delimiter, escape and mask
    d = 8'($urandom);
    write_reg(hdlcd_pkg::CFG_MIN_FRAME, 16'd2);
    write_reg(hdlcd_pkg::CFG_MAX_FRAME, 16'hFFFF);
    write_reg(hdlcd_pkg::CFG_DELIM, {8'($urandom), d});
    write_reg(hdlcd_pkg::CFG_ESCAPE, {8'($urandom), d ^ 8'($urandom_range(1, 255))});
    write_reg(hdlcd_pkg::CFG_ESC_XOR, 16'($urandom));
    end_writes();
    queue_random(300, 40);
    drain();

    tail_quiet = 1'b1;
    queue_random(150, 20);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
